@@ src/rtr_pkg.sv @@
`default_nettype none
package rtr_pkg;

  // widths of the stream fields
  localparam int unsigned ChW   = 21;
  localparam int unsigned TypeW = 2;
  localparam int unsigned LenW  = 3;
  localparam int unsigned ZcW   = 2;
  localparam int unsigned HcW   = 3;

  // token type codes
  localparam logic [TypeW-1:0] TokNull  = 2'd0;
  localparam logic [TypeW-1:0] TokGroup = 2'd1;
  localparam logic [TypeW-1:0] TokCount = 2'd2;

  // token lengths
  localparam logic [LenW-1:0] LenNone    = 3'd0;
  localparam logic [LenW-1:0] LenNullMax = 3'd4;
  localparam logic [LenW-1:0] LenCount   = 3'd1;

  // hex digits in a \uXXXX escape
  localparam logic [HcW-1:0] HexDigits = 3'd4;
  localparam logic [ZcW-1:0] ZeroMax   = 2'd3;

  // character codes
  localparam logic [ChW-1:0] ChBslash = 21'h5C;
  localparam logic [ChW-1:0] ChLt     = 21'h3C;
  localparam logic [ChW-1:0] ChGt     = 21'h3E;
  localparam logic [ChW-1:0] ChLbrace = 21'h7B;
  localparam logic [ChW-1:0] ChRbrace = 21'h7D;
  localparam logic [ChW-1:0] ChComma  = 21'h2C;
  localparam logic [ChW-1:0] ChLowU   = 21'h75;
  localparam logic [ChW-1:0] ChZero   = 21'h30;
  localparam logic [ChW-1:0] ChOne    = 21'h31;
  localparam logic [ChW-1:0] ChSeven  = 21'h37;
  localparam logic [ChW-1:0] ChNine   = 21'h39;
  localparam logic [ChW-1:0] ChLowA   = 21'h61;
  localparam logic [ChW-1:0] ChLowF   = 21'h66;
  localparam logic [ChW-1:0] ChLowZ   = 21'h7A;
  localparam logic [ChW-1:0] ChUpA    = 21'h41;
  localparam logic [ChW-1:0] ChUpF    = 21'h46;
  localparam logic [ChW-1:0] ChUpZ    = 21'h5A;
  localparam logic [ChW-1:0] ChDollar = 21'h24;
  localparam logic [ChW-1:0] ChUscore = 21'h5F;

  // scanner phase, one-hot
  typedef enum logic [8:0] {
    PhIdle   = 9'b000000001,
    PhNul    = 9'b000000010,
    PhGFirst = 9'b000000100,
    PhGBody  = 9'b000001000,
    PhGU     = 9'b000010000,
    PhGHex   = 9'b000100000,
    PhCFirst = 9'b001000000,
    PhCDig1  = 9'b010000000,
    PhCDig2  = 9'b100000000
  } phase_e;

  // character classes of one code point
  typedef struct packed {
    logic is_digit;
    logic is_word;
    logic is_hex;
    logic is_oct;
    logic is_zero;
    logic is_bslash;
    logic is_lt;
    logic is_gt;
    logic is_lbrace;
    logic is_rbrace;
    logic is_comma;
    logic is_u;
  } char_class_t;

  // one registered input request
  typedef struct packed {
    logic           kind;
    logic [ChW-1:0] ch;
    logic           allow_null_char;
    logic           allow_group_name;
    logic           allow_count_quantifier;
  } scan_item_t;

  // scanner result for the current request
  typedef struct packed {
    logic             valid;
    logic             accepted;
    logic [TypeW-1:0] token_type;
    logic [LenW-1:0]  token_length;
  } scan_res_t;

endpackage
`default_nettype wire

@@ src/rtr_char_class.sv @@
`default_nettype none
module rtr_char_class (
  input  wire logic [rtr_pkg::ChW-1:0] ch_i,
  output rtr_pkg::char_class_t         cls_o
);

  logic digit;
  logic lower;
  logic upper;

  // range checks
  assign digit = (ch_i >= rtr_pkg::ChZero) && (ch_i <= rtr_pkg::ChNine);
  assign lower = (ch_i >= rtr_pkg::ChLowA) && (ch_i <= rtr_pkg::ChLowZ);
  assign upper = (ch_i >= rtr_pkg::ChUpA) && (ch_i <= rtr_pkg::ChUpZ);

  // class flags
  always_comb begin
    cls_o.is_digit  = digit;
    cls_o.is_word   = digit || lower || upper ||
                      (ch_i == rtr_pkg::ChDollar) || (ch_i == rtr_pkg::ChUscore);
    cls_o.is_hex    = digit ||
                      ((ch_i >= rtr_pkg::ChLowA) && (ch_i <= rtr_pkg::ChLowF)) ||
                      ((ch_i >= rtr_pkg::ChUpA) && (ch_i <= rtr_pkg::ChUpF));
    cls_o.is_oct    = (ch_i >= rtr_pkg::ChOne) && (ch_i <= rtr_pkg::ChSeven);
    cls_o.is_zero   = (ch_i == rtr_pkg::ChZero);
    cls_o.is_bslash = (ch_i == rtr_pkg::ChBslash);
    cls_o.is_lt     = (ch_i == rtr_pkg::ChLt);
    cls_o.is_gt     = (ch_i == rtr_pkg::ChGt);
    cls_o.is_lbrace = (ch_i == rtr_pkg::ChLbrace);
    cls_o.is_rbrace = (ch_i == rtr_pkg::ChRbrace);
    cls_o.is_comma  = (ch_i == rtr_pkg::ChComma);
    cls_o.is_u      = (ch_i == rtr_pkg::ChLowU);
  end

endmodule
`default_nettype wire

@@ src/rtr_scan_fsm.sv @@
`default_nettype none
module rtr_scan_fsm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire rtr_pkg::scan_item_t item_i,
  output rtr_pkg::scan_res_t       res_o
);

  rtr_pkg::phase_e          phase_q, phase_d;
  logic [rtr_pkg::ZcW-1:0]  zc_q, zc_d;
  logic [rtr_pkg::HcW-1:0]  hc_q, hc_d;
  rtr_pkg::char_class_t     cls;

  logic                       fin;
  logic                       ok;
  logic [rtr_pkg::TypeW-1:0]  ttype;
  logic [rtr_pkg::LenW-1:0]   tlen;
  logic [rtr_pkg::ZcW-1:0]    zc_inc;
  logic [rtr_pkg::HcW-1:0]    hc_inc;

  rtr_char_class u_cls (
    .ch_i  (item_i.ch),
    .cls_o (cls)
  );

  assign zc_inc = zc_q + 2'd1;
  assign hc_inc = hc_q + 3'd1;

  // next phase and result
  always_comb begin
    phase_d = phase_q;
    zc_d    = zc_q;
    hc_d    = hc_q;
    fin     = 1'b0;
    ok      = 1'b0;
    ttype   = rtr_pkg::TokNull;
    tlen    = rtr_pkg::LenNone;
    if (item_i.kind) begin
      zc_d = '0;
      hc_d = '0;
      if (cls.is_bslash) begin
        if (!item_i.allow_null_char) fin = 1'b1;
        else phase_d = rtr_pkg::PhNul;
      end else if (item_i.allow_group_name && cls.is_lt) begin
        phase_d = rtr_pkg::PhGFirst;
      end else if (item_i.allow_count_quantifier && cls.is_lbrace) begin
        phase_d = rtr_pkg::PhCFirst;
      end else begin
        fin = 1'b1;
      end
    end else begin
      case (phase_q)
        rtr_pkg::PhNul: begin
          if (cls.is_zero) begin
            zc_d = zc_inc;
            if (zc_inc == rtr_pkg::ZeroMax) begin
              fin  = 1'b1;
              ok   = 1'b1;
              tlen = rtr_pkg::LenNullMax;
            end
          end else if (zc_q == '0 || cls.is_oct) begin
            fin = 1'b1;
          end else begin
            fin  = 1'b1;
            ok   = 1'b1;
            tlen = {1'b0, zc_q} + 3'd1;
          end
        end
        rtr_pkg::PhGFirst, rtr_pkg::PhGBody: begin
          if (cls.is_gt) begin
            fin   = 1'b1;
            ok    = (phase_q == rtr_pkg::PhGBody);
            ttype = (phase_q == rtr_pkg::PhGBody) ? rtr_pkg::TokGroup : rtr_pkg::TokNull;
          end else if (cls.is_word) begin
            phase_d = rtr_pkg::PhGBody;
          end else if (cls.is_bslash) begin
            phase_d = rtr_pkg::PhGU;
          end else begin
            fin = 1'b1;
          end
        end
        rtr_pkg::PhGU: begin
          if (!cls.is_u) begin
            fin = 1'b1;
          end else begin
            hc_d    = '0;
            phase_d = rtr_pkg::PhGHex;
          end
        end
        rtr_pkg::PhGHex: begin
          if (!cls.is_hex) begin
            fin = 1'b1;
          end else if (hc_inc >= rtr_pkg::HexDigits) begin
            hc_d    = '0;
            phase_d = rtr_pkg::PhGBody;
          end else begin
            hc_d = hc_inc;
          end
        end
        rtr_pkg::PhCFirst: begin
          if (!cls.is_digit) fin = 1'b1;
          else phase_d = rtr_pkg::PhCDig1;
        end
        rtr_pkg::PhCDig1, rtr_pkg::PhCDig2: begin
          if (cls.is_digit) begin
            phase_d = phase_q;
          end else if (cls.is_comma && phase_q == rtr_pkg::PhCDig1) begin
            phase_d = rtr_pkg::PhCDig2;
          end else if (cls.is_rbrace) begin
            fin   = 1'b1;
            ok    = 1'b1;
            ttype = rtr_pkg::TokCount;
            tlen  = rtr_pkg::LenCount;
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          phase_d = rtr_pkg::PhIdle;
        end
      endcase
    end
    // a result ends the scan
    if (fin) begin
      phase_d = rtr_pkg::PhIdle;
      zc_d    = '0;
      hc_d    = '0;
    end
  end

  assign res_o.valid        = fin;
  assign res_o.accepted     = fin && ok;
  assign res_o.token_type   = (fin && ok) ? ttype : rtr_pkg::TokNull;
  assign res_o.token_length = (fin && ok) ? tlen : rtr_pkg::LenNone;

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rtr_pkg::PhIdle;
      zc_q    <= '0;
      hc_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      zc_q    <= zc_d;
      hc_q    <= hc_d;
    end
  end

endmodule
`default_nettype wire

@@ src/regex_token_recognizer.sv @@
// Regular-expression token recognizer, one character per request.
// Slave channel: s_axis_tuser_i is the kind (1 begins a scan, 0 continues);
// s_axis_tdata_i carries the character code point (0 is end of input) and the
// three allow flags, which are only looked at on a begin request.
// Master channel: one result per finished scan; m_axis_tuser_o is the accept
// flag, m_axis_tdata_o holds token type and token length (both 0 on reject).
// After a result the block drops characters until the next begin request;
// a begin during a scan drops the old scan silently.
// A request is taken into the input register, scanned from there, and its
// result is registered in the output register before the master side sees it.
// Throughput: one request per cycle while no finished scan is held up by a
// stalled output register; the scanner state machine steps once per request.
// Stalls: the output register holds a result until m_axis_tready_i; while it
// is full and not ready, a request that would finish a scan waits in the input register and
// s_axis_tready_o drops, requests that give no result keep flowing.
// Reset: input and output registers empty, scanner idle waiting for a begin.
`default_nettype none
module regex_token_recognizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // ch[20:0], allow_null_char[21],
                                            // allow_group_name[22],
                                            // allow_count_quantifier[23]
  input  wire logic        s_axis_tuser_i,  // kind[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // token_type[1:0], token_length[4:2],
                                            // zero[7:5]
  output logic             m_axis_tuser_o   // accepted[0]
);

  logic                in_valid_q, in_valid_d;
  rtr_pkg::scan_item_t item_q;
  rtr_pkg::scan_res_t  res;
  logic                step;
  logic                load;
  logic                s_take;

  logic                      out_valid_q, out_valid_d;
  logic                      out_acc_q;
  logic [rtr_pkg::TypeW-1:0] out_type_q;
  logic [rtr_pkg::LenW-1:0]  out_len_q;

  rtr_scan_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res)
  );

  // input register advances unless its result would overwrite a stalled one
  assign step            = in_valid_q && (!res.valid || !out_valid_q || m_axis_tready_i);
  assign load            = step && res.valid;
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_take || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      item_q.kind                   <= s_axis_tuser_i;
      item_q.ch                     <= s_axis_tdata_i[20:0];
      item_q.allow_null_char        <= s_axis_tdata_i[21];
      item_q.allow_group_name       <= s_axis_tdata_i[22];
      item_q.allow_count_quantifier <= s_axis_tdata_i[23];
    end
  end

  // output register
  assign out_valid_d = load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_acc_q  <= res.accepted;
      out_type_q <= res.token_type;
      out_len_q  <= res.token_length;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_acc_q;
  assign m_axis_tdata_o  = {3'b000, out_len_q, out_type_q};

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !load)
    else $error("result register overwritten while stalled");

  // a reject carries zero type and length
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_acc_q) |->
      (out_type_q == rtr_pkg::TokNull && out_len_q == rtr_pkg::LenNone))
    else $error("reject result with nonzero fields");

  // an accepted null escape spans two to four characters
  a_null_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_acc_q && out_type_q == rtr_pkg::TokNull) |->
      (out_len_q >= 3'd2 && out_len_q <= rtr_pkg::LenNullMax))
    else $error("null escape length out of range");

  // a loaded result shows on the master side next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule
`default_nettype wire

@@ test/regex_token_recognizer_chk.sv @@
`timescale 1ns / 1ps
module regex_token_recognizer_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,  // ch[20:0], allow_null_char[21],
                                  // allow_group_name[22],
                                  // allow_count_quantifier[23]
  input  logic        s_tuser_i,  // kind[0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,  // token_type[1:0], token_length[4:2], zero[7:5]
  input  logic        m_tuser_i,  // accepted[0]
  output int          fails_o,
  output int          pending_o,
  output int          items_o,
  output int          scanned_o,
  output int          accepts_o,
  output int          rejects_o
);

  typedef struct packed {
    logic                      accepted;
    logic [rtr_pkg::TypeW-1:0] tok_type;
    logic [rtr_pkg::LenW-1:0]  tok_len;
  } token_res_t;

  // scanner copy kept in step with every request
  rtr_pkg::phase_e         scan_ph;
  logic [rtr_pkg::ZcW-1:0] zeros;
  logic [rtr_pkg::HcW-1:0] hexes;
  token_res_t              expected_tokens[$];

  function automatic logic digit_c(logic [rtr_pkg::ChW-1:0] c);
    return c >= rtr_pkg::ChZero && c <= rtr_pkg::ChNine;
  endfunction

  function automatic logic hex_c(logic [rtr_pkg::ChW-1:0] c);
    return digit_c(c) || (c >= rtr_pkg::ChLowA && c <= rtr_pkg::ChLowF) ||
           (c >= rtr_pkg::ChUpA && c <= rtr_pkg::ChUpF);
  endfunction

  function automatic logic word_c(logic [rtr_pkg::ChW-1:0] c);
    return (c >= rtr_pkg::ChLowA && c <= rtr_pkg::ChLowZ) ||
           (c >= rtr_pkg::ChUpA && c <= rtr_pkg::ChUpZ) || digit_c(c) ||
           c == rtr_pkg::ChDollar || c == rtr_pkg::ChUscore;
  endfunction

  // a finished scan leaves one token result and returns to idle
  task automatic close_scan(input logic ok, input logic [rtr_pkg::TypeW-1:0] ty,
                            input logic [rtr_pkg::LenW-1:0] len);
    token_res_t r;
    r.accepted = ok;
    r.tok_type = ok ? ty : rtr_pkg::TokNull;
    r.tok_len  = ok ? len : rtr_pkg::LenNone;
    expected_tokens.push_back(r);
    scan_ph = rtr_pkg::PhIdle;
    zeros   = '0;
    hexes   = '0;
  endtask

  task automatic reject_scan();
    close_scan(1'b0, rtr_pkg::TokNull, rtr_pkg::LenNone);
  endtask

  // one character of a group name
  task automatic group_char(input logic [rtr_pkg::ChW-1:0] c);
    if (c == rtr_pkg::ChGt) close_scan(1'b1, rtr_pkg::TokGroup, rtr_pkg::LenNone);
    else if (c == rtr_pkg::ChBslash) scan_ph = rtr_pkg::PhGU;
    else if (!word_c(c)) reject_scan();
  endtask

  // allow is {count, group, null}
  task automatic scan_step(input logic start, input logic [rtr_pkg::ChW-1:0] c,
                           input logic [2:0] allow);
    if (start || scan_ph != rtr_pkg::PhIdle) scanned_o++;
    if (start) begin
      zeros = '0;
      hexes = '0;
      if (c == rtr_pkg::ChBslash) begin
        if (allow[0]) scan_ph = rtr_pkg::PhNul;
        else reject_scan();
      end else if (allow[1] && c == rtr_pkg::ChLt) begin
        scan_ph = rtr_pkg::PhGFirst;
      end else if (allow[2] && c == rtr_pkg::ChLbrace) begin
        scan_ph = rtr_pkg::PhCFirst;
      end else begin
        reject_scan();
      end
    end else begin
      case (scan_ph)
        rtr_pkg::PhNul: begin
          if (c == rtr_pkg::ChZero) begin
            zeros = zeros + 1'b1;
            if (zeros == rtr_pkg::ZeroMax)
              close_scan(1'b1, rtr_pkg::TokNull, rtr_pkg::LenNullMax);
          end else if (zeros == '0 || (c >= rtr_pkg::ChOne && c <= rtr_pkg::ChSeven)) begin
            reject_scan();
          end else begin
            close_scan(1'b1, rtr_pkg::TokNull,
                       rtr_pkg::LenW'(zeros) + rtr_pkg::LenW'(1));
          end
        end
        rtr_pkg::PhGFirst: begin
          if (c == rtr_pkg::ChGt) begin
            reject_scan();
          end else begin
            scan_ph = rtr_pkg::PhGBody;
            group_char(c);
          end
        end
        rtr_pkg::PhGBody: group_char(c);
        rtr_pkg::PhGU: begin
          if (c != rtr_pkg::ChLowU) begin
            reject_scan();
          end else begin
            hexes   = '0;
            scan_ph = rtr_pkg::PhGHex;
          end
        end
        rtr_pkg::PhGHex: begin
          if (!hex_c(c)) begin
            reject_scan();
          end else begin
            hexes = hexes + 1'b1;
            if (hexes >= rtr_pkg::HexDigits) begin
              hexes   = '0;
              scan_ph = rtr_pkg::PhGBody;
            end
          end
        end
        rtr_pkg::PhCFirst: begin
          if (!digit_c(c)) reject_scan();
          else scan_ph = rtr_pkg::PhCDig1;
        end
        rtr_pkg::PhCDig1, rtr_pkg::PhCDig2: begin
          if (c == rtr_pkg::ChComma && scan_ph == rtr_pkg::PhCDig1)
            scan_ph = rtr_pkg::PhCDig2;
          else if (c == rtr_pkg::ChRbrace)
            close_scan(1'b1, rtr_pkg::TokCount, rtr_pkg::LenCount);
          else if (!digit_c(c))
            reject_scan();
        end
        default: scan_ph = rtr_pkg::PhIdle;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails_o++;
    end
  endtask

  // watch both channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    token_res_t want;
    if (!rst_ni) begin
      scan_ph = rtr_pkg::PhIdle;
      zeros   = '0;
      hexes   = '0;
      expected_tokens.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        items_o++;
        scan_step(s_tuser_i, s_tdata_i[20:0], s_tdata_i[23:21]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("token result with no scan pending: accepted %0b, tdata %0h",
                 m_tuser_i, m_tdata_i);
          fails_o++;
        end else begin
          want = expected_tokens.pop_front();
          if (want.accepted) accepts_o++;
          else rejects_o++;
          check_field("accepted", 8'(want.accepted), 8'(m_tuser_i));
          check_field("token_type", 8'(want.tok_type), 8'(m_tdata_i[1:0]));
          check_field("token_length", 8'(want.tok_len), 8'(m_tdata_i[4:2]));
          check_field("tdata padding", 8'd0, 8'(m_tdata_i[7:5]));
        end
      end
    end
    pending_o = expected_tokens.size();
  end

endmodule

@@ test/regex_token_recognizer_tb.sv @@
`timescale 1ns / 1ps
module regex_token_recognizer_tb;

  typedef logic [rtr_pkg::ChW-1:0] char_t;

  localparam logic KindCont  = 1'b0;
  localparam logic KindStart = 1'b1;

  // allow flags as {count, group, null}
  localparam logic [2:0] AllowNone = 3'b000;
  localparam logic [2:0] AllowNul  = 3'b001;
  localparam logic [2:0] AllowGrp  = 3'b010;
  localparam logic [2:0] AllowCnt  = 3'b100;
  localparam logic [2:0] AllowAll  = 3'b111;

  localparam char_t ChEnd = 21'd0;
  localparam char_t ChTop = 21'h10FFFF;

  localparam int ItemTarget = 740;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;

  int chk_fails, chk_pending, chk_items, chk_scanned, chk_accepts, chk_rejects;
  int sent_cnt;
  int rx_hold_req;
  logic tx_quiet, tx_force, rx_quiet;
  char_t scan_chars[$];

  regex_token_recognizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  regex_token_recognizer_chk chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .fails_o    (chk_fails),
    .pending_o  (chk_pending),
    .items_o    (chk_items),
    .scanned_o  (chk_scanned),
    .accepts_o  (chk_accepts),
    .rejects_o  (chk_rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // character pickers
  function automatic char_t rand_digit();
    return char_t'(rtr_pkg::ChZero + $urandom_range(0, 9));
  endfunction

  function automatic char_t rand_hex();
    case ($urandom_range(0, 2))
      0:       return rand_digit();
      1:       return char_t'(rtr_pkg::ChLowA + $urandom_range(0, 5));
      default: return char_t'(rtr_pkg::ChUpA + $urandom_range(0, 5));
    endcase
  endfunction

  function automatic char_t rand_word();
    case ($urandom_range(0, 4))
      0:       return char_t'(rtr_pkg::ChLowA + $urandom_range(0, 25));
      1:       return char_t'(rtr_pkg::ChUpA + $urandom_range(0, 25));
      2:       return rand_digit();
      3:       return rtr_pkg::ChDollar;
      default: return rtr_pkg::ChUscore;
    endcase
  endfunction

  function automatic char_t rand_noise();
    case ($urandom_range(0, 3))
      0: return char_t'($urandom_range(0, 127));
      1: return char_t'($urandom_range(0, ChTop));
      2: return rand_digit();
      default: begin
        case ($urandom_range(0, 9))
          0:       return ChEnd;
          1:       return rtr_pkg::ChBslash;
          2:       return rtr_pkg::ChLt;
          3:       return rtr_pkg::ChGt;
          4:       return rtr_pkg::ChLbrace;
          5:       return rtr_pkg::ChRbrace;
          6:       return rtr_pkg::ChComma;
          7:       return rtr_pkg::ChLowU;
          8:       return ChTop;
          default: return rtr_pkg::ChZero;
        endcase
      end
    endcase
  endfunction

  // one request, after a random gap, held until taken
  task automatic push_char(input logic kind, input char_t ch,
                           input logic [2:0] allow);
    int gap;
    if ($urandom_range(0, 23) == 0) tx_quiet = !tx_quiet;
    gap = (tx_quiet || tx_force) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {allow, ch};
    do @(posedge clk_i); while (!s_tready);
    sent_cnt++;
  endtask

  // first character opens the scan, the rest continue it
  task automatic run_chars(input logic [2:0] allow);
    foreach (scan_chars[i])
      push_char(i == 0 ? KindStart : KindCont, scan_chars[i],
                i == 0 ? allow : 3'($urandom_range(0, 7)));
  endtask

  task automatic drain();
    wait (chk_items == sent_cnt && chk_pending == 0);
  endtask

  task automatic build_null();
    scan_chars.push_back(rtr_pkg::ChBslash);
    repeat ($urandom_range(0, 4)) scan_chars.push_back(rtr_pkg::ChZero);
    case ($urandom_range(0, 3))
      0:       scan_chars.push_back(ChEnd);
      1:       scan_chars.push_back(char_t'(rtr_pkg::ChOne + $urandom_range(0, 6)));
      2:       scan_chars.push_back(rand_noise());
      default: scan_chars.push_back(char_t'(rtr_pkg::ChSeven + $urandom_range(1, 2)));
    endcase
  endtask

  task automatic build_group();
    scan_chars.push_back(rtr_pkg::ChLt);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 7) < 6) begin
        scan_chars.push_back(rand_word());
      end else begin
        scan_chars.push_back(rtr_pkg::ChBslash);
        if ($urandom_range(0, 7) == 0) begin
          scan_chars.push_back(rand_noise());
        end else begin
          scan_chars.push_back(rtr_pkg::ChLowU);
          // now and then a short escape
          repeat ($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : 4)
            scan_chars.push_back(rand_hex());
        end
      end
    end
    scan_chars.push_back(rtr_pkg::ChGt);
  endtask

  task automatic build_count();
    scan_chars.push_back(rtr_pkg::ChLbrace);
    repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3))
      scan_chars.push_back(rand_digit());
    if ($urandom_range(0, 1)) begin
      scan_chars.push_back(rtr_pkg::ChComma);
      repeat ($urandom_range(0, 3)) scan_chars.push_back(rand_digit());
    end
    scan_chars.push_back(rtr_pkg::ChRbrace);
  endtask

  // break some sequences: a bad character, a cut, an early end of input, an extra character
  task automatic mangle();
    int cut;
    case ($urandom_range(0, 7))
      0: scan_chars[$urandom_range(1, scan_chars.size() - 1)] = rand_noise();
      1: begin
        cut = $urandom_range(1, scan_chars.size() - 1);
        while (scan_chars.size() > cut) void'(scan_chars.pop_back());
      end
      2: begin
        cut = $urandom_range(1, scan_chars.size() - 1);
        while (scan_chars.size() > cut) void'(scan_chars.pop_back());
        scan_chars.push_back(ChEnd);
      end
      3: scan_chars.push_back(rand_noise());
      default: ;
    endcase
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    m_tready = 1'b0;
    rx_quiet = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        if ($urandom_range(0, 23) == 0) rx_quiet = !rx_quiet;
        stall = rx_quiet ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // stimulus
  initial begin
    int kind_sel;
    logic [2:0] allow;
    logic hold_done, pause_done;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    s_tdata  = '0;
    tx_quiet = 1'b0;
    tx_force = 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // continue with no scan open is dropped
    push_char(KindCont, rtr_pkg::ChLowA, AllowAll);
    // backslash while null escapes are off
    push_char(KindStart, rtr_pkg::ChBslash, AllowGrp | AllowCnt);
    // third zero closes the escape at full length
    push_char(KindStart, rtr_pkg::ChBslash, AllowNul);
    repeat (3) push_char(KindCont, rtr_pkg::ChZero, AllowNone);
    // octal digit after a zero
    push_char(KindStart, rtr_pkg::ChBslash, AllowNul);
    push_char(KindCont, rtr_pkg::ChZero, AllowNone);
    push_char(KindCont, rtr_pkg::ChSeven, AllowNone);
    // end of input after one zero
    push_char(KindStart, rtr_pkg::ChBslash, AllowAll);
    push_char(KindCont, rtr_pkg::ChZero, AllowAll);
    push_char(KindCont, ChEnd, AllowAll);
    // empty group name
    push_char(KindStart, rtr_pkg::ChLt, AllowGrp);
    push_char(KindCont, rtr_pkg::ChGt, AllowNone);
    // name made of one unicode escape
    push_char(KindStart, rtr_pkg::ChLt, AllowGrp);
    push_char(KindCont, rtr_pkg::ChBslash, AllowNone);
    push_char(KindCont, rtr_pkg::ChLowU, AllowNone);
    push_char(KindCont, rtr_pkg::ChZero, AllowNone);
    push_char(KindCont, rtr_pkg::ChUpF, AllowNone);
    push_char(KindCont, rtr_pkg::ChLowA, AllowNone);
    push_char(KindCont, rtr_pkg::ChNine, AllowNone);
    push_char(KindCont, rtr_pkg::ChGt, AllowNone);
    // new begin drops an open quantifier, then a brace with no digit
    push_char(KindStart, rtr_pkg::ChLbrace, AllowCnt);
    push_char(KindCont, rtr_pkg::ChOne, AllowNone);
    push_char(KindCont, rtr_pkg::ChComma, AllowNone);
    push_char(KindStart, rtr_pkg::ChLbrace, AllowCnt);
    push_char(KindCont, rtr_pkg::ChRbrace, AllowNone);
    // highest code point starts nothing
    push_char(KindStart, ChTop, AllowAll);
    s_tvalid <= 1'b0;
    drain();

    while (sent_cnt < ItemTarget) begin
      // output held off while requests keep coming
      if (!hold_done && sent_cnt > 250) begin
        hold_done   = 1'b1;
        rx_hold_req = 160;
        tx_force    = 1'b1;
        repeat (24) push_char(KindStart, rtr_pkg::ChUpZ, AllowNone);
        tx_force = 1'b0;
      end
      // sender waits for every token result
      if (!pause_done && sent_cnt > 500) begin
        pause_done = 1'b1;
        s_tvalid <= 1'b0;
        drain();
      end
      kind_sel = $urandom_range(0, 15);
      if (kind_sel < 12) begin
        scan_chars.delete();
        case (kind_sel % 3)
          0:       build_null();
          1:       build_group();
          default: build_count();
        endcase
        mangle();
        allow = 3'($urandom_range(0, 7)) | (AllowNul << (kind_sel % 3));
        if ($urandom_range(0, 7) == 0) allow &= ~(AllowNul << (kind_sel % 3));
        run_chars(allow);
      end else if (kind_sel < 14) begin
        push_char(1'($urandom_range(0, 1)), rand_noise(), 3'($urandom_range(0, 7)));
      end else begin
        repeat ($urandom_range(1, 3))
          push_char(KindCont, rand_noise(), 3'($urandom_range(0, 7)));
      end
    end

    s_tvalid <= 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    $display("sent %0d characters, %0d of them inside a scan", sent_cnt, chk_scanned);
    $display("token results: %0d accepted, %0d rejected", chk_accepts, chk_rejects);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
